// ----- design/fprc_pkg.sv -----
// ----------------------------------------------------------------------------
// fprc_pkg
// Shared types and constants for the FIFO page replacement core.
// ----------------------------------------------------------------------------
`default_nettype none

package fprc_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;

  // slot index and fill count widths follow from the frame count
  localparam int SLOT_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FILL_W  = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W   = 4;
  localparam int EFF_W   = (FILL_W > CFG_W) ? FILL_W : CFG_W;

  // fixed result field widths
  localparam int OUT_SLOT_W = 3;
  localparam int COUNT_W    = 32;
  localparam int IN_TDATA_W  = ((PAGE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 1 + OUT_SLOT_W + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [FILL_W-1:0]    fill_t;

  // per-cell control from the replacement logic
  typedef struct packed {
    logic lookup;  // cell lies in the searched range
    logic write;   // load the broadcast page into this cell
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/fprc_cell.sv -----
// ----------------------------------------------------------------------------
// fprc_cell
// One frame of the associative row: holds a page, compares it against the
// broadcast reference and extends the lowest-match chain to its neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module fprc_cell (
  input  wire                     clk_i,
  input  wire fprc_pkg::page_t      page_i,
  input  wire fprc_pkg::cell_ctrl_t ctrl_i,
  input  wire                     found_i,
  output logic                    found_o,
  output logic                    hit_o
);
  import fprc_pkg::*;

  page_t page_q;
  logic  match;

  assign match   = ctrl_i.lookup && (page_q == page_i);
  // a lower cell already matched: pass the flag on, claim nothing
  assign hit_o   = match && !found_i;
  assign found_o = found_i || match;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      page_q <= page_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/fifo_page_replacement_core.sv -----
// ----------------------------------------------------------------------------
// fifo_page_replacement_core
// FIFO page replacement over a fully associative row of frame cells.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat contents (low bit first)
//  s_axis    in   tdata: page[15:0]
//  m_axis    out  tdata: fault[0], slot[3:1], fault_count[35:4], zero pad
//  cfg       in   cfg_data_i: frames_in_use[3:0]
//
//  One reference per cycle unless stalled: the page is compared across
//  all cells in the cycle it is accepted and the result is registered
//  for the next. The lowest-match chain through the cells sets the
//  cycle's depth. A new page is taken while the result register is empty
//  or being drained. Reset empties all frames and clears the pointer and
//  fault count; frame contents are not cleared, only the fill count gates them.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_page_replacement_core (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire [fprc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // page
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [fprc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // fault, slot, fault_count
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire [fprc_pkg::CFG_W-1:0]           cfg_data_i      // frames_in_use
);
  import fprc_pkg::*;

  logic [CFG_W-1:0]   frames_q;
  fill_t              filled_q, filled_d;
  slot_t              ptr_q, ptr_d;
  logic [COUNT_W-1:0] faults_q, faults_d;

  logic                  out_valid_q;
  logic                  out_fault_q;
  logic [OUT_SLOT_W-1:0] out_slot_q;
  logic [COUNT_W-1:0]    out_count_q;

  page_t             page;
  logic              s_fire;
  logic [EFF_W-1:0]  cfg_ext;
  fill_t             n_eff;
  fill_t             lim;
  logic              hit;
  slot_t             hit_slot;
  slot_t             ptr_use;
  fill_t             ptr_inc;
  slot_t             new_slot;
  slot_t             res_slot;
  logic              fill_path;

  cell_ctrl_t        ctrl  [MAX_FRAMES];
  logic [MAX_FRAMES:0]   chain;
  logic [MAX_FRAMES-1:0] hit_vec;

  assign page          = s_axis_tdata[PAGE_BITS-1:0];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // clamp the frame count into 1..MAX_FRAMES
  always_comb begin
    cfg_ext = EFF_W'(frames_q);
    if (cfg_ext == '0) begin
      n_eff = FILL_W'(1);
    end else if (cfg_ext > EFF_W'(MAX_FRAMES)) begin
      n_eff = FILL_W'(MAX_FRAMES);
    end else begin
      n_eff = cfg_ext[FILL_W-1:0];
    end
    lim = (filled_q < n_eff) ? filled_q : n_eff;
  end

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    assign ctrl[i].lookup = (FILL_W'(i) < lim);
    assign ctrl[i].write  = s_fire && !hit && (new_slot == SLOT_W'(i));

    fprc_cell u_cell (
      .clk_i   (clk_i),
      .page_i  (page),
      .ctrl_i  (ctrl[i]),
      .found_i (chain[i]),
      .found_o (chain[i+1]),
      .hit_o   (hit_vec[i])
    );
  end

  assign hit = chain[MAX_FRAMES];

  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (hit_vec[i]) begin
        hit_slot = hit_slot | SLOT_W'(i);
      end
    end
  end

  // victim choice: next empty frame while filling, else the round-robin pointer
  always_comb begin
    fill_path = (filled_q < n_eff);
    ptr_use   = (FILL_W'(ptr_q) >= n_eff) ? '0 : ptr_q;
    ptr_inc   = FILL_W'(ptr_use) + FILL_W'(1);
    new_slot  = fill_path ? filled_q[SLOT_W-1:0] : ptr_use;
    res_slot  = hit ? hit_slot : new_slot;

    filled_d = filled_q;
    ptr_d    = ptr_q;
    faults_d = faults_q;
    if (s_fire && !hit) begin
      if (fill_path) begin
        filled_d = filled_q + FILL_W'(1);
      end else begin
        ptr_d = (ptr_inc >= n_eff) ? '0 : ptr_inc[SLOT_W-1:0];
      end
      if (faults_q != '1) begin
        faults_d = faults_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= CFG_W'(MAX_FRAMES);
      filled_q    <= '0;
      ptr_q       <= '0;
      faults_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        frames_q <= cfg_data_i;
      end
      filled_q <= filled_d;
      ptr_q    <= ptr_d;
      faults_q <= faults_d;
      if (s_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register: load on every accepted beat
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_fault_q <= !hit;
      out_slot_q  <= OUT_SLOT_W'(res_slot);
      out_count_q <= faults_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_count_q, out_slot_q, out_fault_q});

  // assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= FILL_W'(MAX_FRAMES))
    else $error("fill count beyond frame count");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one cell claims the hit");

  a_hit_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && hit |=> $stable(filled_q) && $stable(ptr_q) && $stable(faults_q))
    else $error("hit changed replacement state");

  a_fault_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !hit && (faults_q != '1) |=> faults_q == $past(faults_q) + COUNT_W'(1))
    else $error("fault not counted");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !hit && !fill_path |=> FILL_W'(ptr_q) < $past(n_eff))
    else $error("replacement pointer beyond frame count");

endmodule

`default_nettype wire

// ----- sim/fifo_page_replacement_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_replacement_core_test
// Self-checking bench for the FIFO page replacement core. A queue of page
// references feeds a stream driver, and a shadow of the frame table predicts
// fault, slot and fault count for every accepted reference. The bench
// reprograms the frame count between phases, and sender and receiver idle at
// random. One phase holds the result side off long enough to back up input.
// ----------------------------------------------------------------------------

module fifo_page_replacement_core_test;

  import fprc_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 108;

  // packed from the top bit down: fault_count, slot, fault
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [2:0]         slot;
    logic               fault;
  } page_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // page
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // fault, slot, fault_count, pad
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i    = '0;   // frames_in_use

  fifo_page_replacement_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // stimulus and expectation stores
  logic [PAGE_BITS-1:0] pages_to_send[$];
  page_result_t         expected_results[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_on = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // shadow of the frame table
  logic [PAGE_BITS-1:0] frame_pg[MAX_FRAMES];
  int unsigned          fill_n;
  int unsigned          rr_ptr;
  logic [COUNT_W-1:0]   fault_tot;
  logic [CFG_W-1:0]     frames_cfg;

  task automatic report_mismatch(input string field_name, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $time, field_name, exp_v, got_v);
    mismatch_count++;
  endtask

  // Look the page up among the live frames; load it on a miss.
  function automatic page_result_t resolve_page(input logic [PAGE_BITS-1:0] pg);
    page_result_t r;
    int unsigned  eff;
    int unsigned  span;
    bit           found;
    eff = (frames_cfg == 0) ? 1 : ((frames_cfg > MAX_FRAMES) ? MAX_FRAMES : frames_cfg);
    span = (fill_n < eff) ? fill_n : eff;
    found = 1'b0;
    r.slot = '0;
    for (int unsigned k = 0; k < span; k++) begin
      if (!found && frame_pg[k] == pg) begin
        found = 1'b1;
        r.slot = k[2:0];
      end
    end
    if (!found) begin
      if (fill_n < eff) begin
        r.slot = fill_n[2:0];
        frame_pg[fill_n] = pg;
        fill_n++;
      end else begin
        // pointer may sit past a shrunk frame count
        if (rr_ptr >= eff) rr_ptr = 0;
        r.slot = rr_ptr[2:0];
        frame_pg[rr_ptr] = pg;
        rr_ptr++;
        if (rr_ptr >= eff) rr_ptr = 0;
      end
      if (fault_tot != '1) fault_tot++;
    end
    r.fault = !found;
    r.count = fault_tot;
    return r;
  endfunction

  // Driver: hold a beat until taken, then offer the next or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pages_to_send.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pages_to_send.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_on && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Monitor: predict on every input beat, then check result beats in order.
  always @(posedge clk_i or negedge rst_ni) begin
    page_result_t exp_r;
    page_result_t got_r;
    if (!rst_ni) begin
      fill_n     = 0;
      rr_ptr     = 0;
      fault_tot  = '0;
      frames_cfg = CFG_W'(MAX_FRAMES);
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) frames_cfg = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results = {expected_results, resolve_page(s_axis_tdata[PAGE_BITS-1:0])};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = m_axis_tdata[OUT_FIELD_W-1:0];
        if (expected_results.size() == 0) begin
          report_mismatch("unrequested result", '0, m_axis_tdata[31:0]);
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r.fault !== exp_r.fault) begin
            report_mismatch("fault", 32'(exp_r.fault), 32'(got_r.fault));
          end
          if (got_r.slot !== exp_r.slot) begin
            report_mismatch("slot", 32'(exp_r.slot), 32'(got_r.slot));
          end
          if (got_r.count !== exp_r.count) report_mismatch("fault_count", exp_r.count, got_r.count);
          if ((m_axis_tdata >> OUT_FIELD_W) !== '0) begin
            report_mismatch("pad", '0, 32'(m_axis_tdata >> OUT_FIELD_W));
          end
        end
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("fifo_page_replacement_core_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sample on the falling edge so the driver and monitor have settled
  task automatic wait_drained();
    while (pages_to_send.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    wait_drained();
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly references from a narrow window so hits and evictions recur.
  task automatic queue_random_pages(input int unsigned count);
    int unsigned base;
    base = $urandom_range(0, 65535 - 16);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 39) base = $urandom_range(0, 65535 - 16);
      if ($urandom_range(0, 99) < 75) begin
        pages_to_send = {pages_to_send, PAGE_BITS'(base + $urandom_range(0, 11))};
      end else begin
        pages_to_send = {pages_to_send, PAGE_BITS'($urandom_range(0, 65535))};
      end
    end
  endtask

  initial begin
    logic [PAGE_BITS-1:0] fill_and_cycle[] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h5555,
      16'hAAAA, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'hFFFF, 16'h0005, 16'h0000,
      16'h0006, 16'h0007, 16'h0008, 16'h0009};
    logic [CFG_W-1:0] frame_plan[RAND_PHASES] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3,
      4'd6, 4'd2, 4'd5, 4'd4, 4'd7};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill all frames from reset, hit, then evict round the ring
    foreach (fill_and_cycle[i]) pages_to_send = {pages_to_send, fill_and_cycle[i]};
    // shrink while full with the pointer past the new count
    write_frames(4'd4);
    pages_to_send = {pages_to_send, 16'h0064};
    pages_to_send = {pages_to_send, 16'h0009};
    // grow again: two slots now hold the same page, lowest must win
    write_frames(4'd15);
    pages_to_send = {pages_to_send, 16'h0009};
    // zero acts as a single frame
    write_frames(4'd0);
    pages_to_send = {pages_to_send, 16'h0009};
    pages_to_send = {pages_to_send, 16'h0009};
    pages_to_send = {pages_to_send, 16'h1234};

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_frames(frame_plan[ph]);
      case (ph % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 57;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 57;
        end
        default: begin
          tx_idle_pct  = 6;
          rx_stall_pct = 6;
        end
      endcase
      queue_random_pages(PHASE_ITEMS);
      if (ph == 4) begin
        // back up the result path while input keeps coming
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("fifo_page_replacement_core_test: PASS");
    end else begin
      $display("fifo_page_replacement_core_test: FAIL");
    end
    $finish;
  end

endmodule
